FILE: hw/rtl/midi_voice_allocator_defines.svh
// Assertion macros shared by the voice allocator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef MIDI_VOICE_ALLOCATOR_DEFINES_SVH
`define MIDI_VOICE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MVA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("voice allocator check failed");

// next-cycle implication, disabled during reset
`define MVA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("voice allocator check failed");

`endif

FILE: hw/rtl/mva_pkg.sv
// Types and constants for the MIDI voice allocator.
// No dependencies; used by mva_scan and midi_voice_allocator.
package mva_pkg;

   // event opcodes
   localparam logic [1:0] OP_NOTE_ON = 2'd0;
   localparam logic [1:0] OP_CTRL    = 2'd1;

   // sustain pedal controller and its on threshold
   localparam logic [6:0] SUSTAIN_CC  = 7'd64;
   localparam logic [6:0] SUSTAIN_MIN = 7'd63;

   localparam logic [4:0] CHANNEL_RESET = 5'd1;

   // incoming event word
   typedef struct packed {
      logic [1:0]  opcode;
      logic [4:0]  channel;
      logic [6:0]  key;
      logic [6:0]  amount;
      logic [31:0] time_ms;
   } req_type;

   // result word
   typedef struct packed {
      logic       acted;
      logic [2:0] voice;
      logic       gate;
      logic [6:0] note;
      logic [6:0] velocity;
   } rsp_type;

   // sequencer to scan unit
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctrl_type;

endpackage

FILE: hw/rtl/mva_scan.sv
// Voice scan unit: one voice per step, tracks held key match and oldest free voice.
// Depends on mva_pkg.
module mva_scan #(
   parameter int VOICES = 8,
   localparam int IDXW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mva_pkg::scan_ctrl_type ctrl,
   input  logic [IDXW-1:0]        idx,
   input  logic                   gate,
   input  logic [6:0]             note,
   input  logic [31:0]            stamp,
   input  logic [6:0]             key,
   output logic                   held_found,
   output logic [IDXW-1:0]        held_idx,
   output logic [IDXW-1:0]        free_idx
);

   logic            held_found_ff, held_found_in;
   logic [IDXW-1:0] held_idx_ff, held_idx_in;
   logic            free_found_ff, free_found_in;
   logic [IDXW-1:0] free_idx_ff, free_idx_in;
   logic [31:0]     best_ff, best_in;
   logic            is_held;
   logic            is_older;

   // shared compare: key match and stamp order for the current voice
   assign is_held  = gate && (note == key);
   assign is_older = !gate && (!free_found_ff || (stamp < best_ff));

   always_comb begin
      held_found_in = held_found_ff;
      held_idx_in   = held_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      best_in       = best_ff;
      if (ctrl.clear) begin
         held_found_in = 1'b0;
         held_idx_in   = '0;
         free_found_in = 1'b0;
         free_idx_in   = '0;   // voice 0 when nothing is free
         best_in       = '0;
      end else if (ctrl.step) begin
         // first match wins
         if (!held_found_ff && is_held) begin
            held_found_in = 1'b1;
            held_idx_in   = idx;
         end
         // strict compare keeps the lowest index on ties
         if (is_older) begin
            free_found_in = 1'b1;
            free_idx_in   = idx;
            best_in       = stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         held_found_ff <= held_found_in;
         free_found_ff <= free_found_in;
      end
      held_idx_ff <= held_idx_in;
      free_idx_ff <= free_idx_in;
      best_ff     <= best_in;
   end

   assign held_found = held_found_ff;
   assign held_idx   = held_idx_ff;
   assign free_idx   = free_idx_ff;

endmodule

FILE: hw/rtl/midi_voice_allocator.sv
// MIDI voice allocator top level: voice table, sequencer, result register.
// The result word is registered once the scan is complete and the result register is free.
// The scan reads one voice table entry per scan cycle.
// The scan unit walks the table once per event; input stalls while busy.
// Reset (synchronous): voice table and sustain cleared, listen channel 1.
`include "midi_voice_allocator_defines.svh"

module midi_voice_allocator #(
   parameter int VOICES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mva_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mva_pkg::rsp_type rsp_word,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data
);

   localparam int IDXW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(VOICES - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDXW-1:0]  idx_ff, idx_in;
   mva_pkg::req_type evt_ff;
   logic [4:0]       listen_ff;
   logic             sustain_ff;
   logic             rsp_valid_ff;
   mva_pkg::rsp_type rsp_ff;

   // voice table
   logic [VOICES-1:0] voice_gate_ff;
   logic [6:0]        voice_note_ff  [VOICES];
   logic [6:0]        voice_level_ff [VOICES];
   logic [31:0]       voice_stamp_ff [VOICES];

   mva_pkg::scan_ctrl_type scan_ctrl;
   logic                   held_found;
   logic [IDXW-1:0]        held_idx;
   logic [IDXW-1:0]        free_idx;

   logic             accept;
   logic             commit;
   logic             ch_hit;
   logic             do_start;
   logic             do_release;
   logic             do_sustain;
   logic [IDXW-1:0]  pick;
   mva_pkg::rsp_type rsp_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign commit    = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      scan_ctrl.clear = 1'b0;
      scan_ctrl.step  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               idx_in   = '0;
               scan_ctrl.clear = 1'b1;
            end
         end
         ST_SCAN: begin
            scan_ctrl.step = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   mva_scan #(
      .VOICES (VOICES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .idx        (idx_ff),
      .gate       (voice_gate_ff[idx_ff]),
      .note       (voice_note_ff[idx_ff]),
      .stamp      (voice_stamp_ff[idx_ff]),
      .key        (evt_ff.key),
      .held_found (held_found),
      .held_idx   (held_idx),
      .free_idx   (free_idx)
   );

   // event decode once the scan is complete
   assign ch_hit     = (evt_ff.channel == listen_ff);
   assign do_start   = ch_hit && (evt_ff.opcode == mva_pkg::OP_NOTE_ON) &&
                       (evt_ff.amount != 7'd0);
   assign do_release = ch_hit && (evt_ff.opcode == mva_pkg::OP_NOTE_ON) &&
                       (evt_ff.amount == 7'd0) && !sustain_ff && held_found;
   assign do_sustain = ch_hit && (evt_ff.opcode == mva_pkg::OP_CTRL) &&
                       (evt_ff.key == mva_pkg::SUSTAIN_CC);
   assign pick       = held_found ? held_idx : free_idx;

   // result word; a released voice keeps its note, which equals the key
   always_comb begin
      rsp_in = '0;
      if (do_start) begin
         rsp_in.acted    = 1'b1;
         rsp_in.voice    = 3'(pick);
         rsp_in.gate     = 1'b1;
         rsp_in.note     = evt_ff.key;
         rsp_in.velocity = evt_ff.amount;
      end else if (do_release) begin
         rsp_in.acted    = 1'b1;
         rsp_in.voice    = 3'(held_idx);
         rsp_in.note     = evt_ff.key;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         listen_ff    <= mva_pkg::CHANNEL_RESET;
         sustain_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_wr_en) begin
            listen_ff <= csr_wr_data;
         end
         if (commit && do_sustain) begin
            sustain_ff <= (evt_ff.amount > mva_pkg::SUSTAIN_MIN);
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // event and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         evt_ff <= req_word;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // voice table update
   always_ff @(posedge clock) begin
      if (reset) begin
         voice_gate_ff <= '0;
         for (int i = 0; i < VOICES; i++) begin
            voice_note_ff[i]  <= '0;
            voice_level_ff[i] <= '0;
            voice_stamp_ff[i] <= '0;
         end
      end else if (commit) begin
         if (do_start) begin
            voice_gate_ff[pick]  <= 1'b1;
            voice_note_ff[pick]  <= evt_ff.key;
            voice_level_ff[pick] <= evt_ff.amount;
            voice_stamp_ff[pick] <= evt_ff.time_ms;
         end else if (do_release) begin
            voice_gate_ff[held_idx]  <= 1'b0;
            voice_level_ff[held_idx] <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   `MVA_ASSERT_NEXT(a_accept_starts_scan, accept, (state_ff == ST_SCAN) && (idx_ff == '0))
   `MVA_ASSERT_IMP(a_quiet_result_zero, rsp_valid_ff && !rsp_ff.acted, rsp_ff == '0)
   `MVA_ASSERT_NEXT(a_sustain_no_act, commit && do_sustain, rsp_valid_ff && !rsp_ff.acted)
   `MVA_ASSERT_NEXT(a_start_gates_voice, commit && do_start, voice_gate_ff[$past(pick)])

endmodule
